@@ src/mlhm_pkg.sv @@
// ----------------------------------------------------------------------------
// mlhm_pkg
// Shared constants and types of the multiprecision low-half multiplier.
// ----------------------------------------------------------------------------
package mlhm_pkg;

  localparam int MAX_LIMBS  = 32;
  localparam int LIMB_BITS  = 64;
  localparam int FIELD_W    = 64;
  localparam int OUT_IDX_W  = 5;

  localparam int IDX_W      = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int CNT_W      = $clog2(MAX_LIMBS + 1);
  localparam int HALF_W     = (LIMB_BITS + 1) / 2;
  localparam int PP_W       = 2 * HALF_W;
  localparam int DRAIN_CYC  = 3;
  localparam int GAP_W      = 2;

  typedef logic [LIMB_BITS-1:0] limb_t;

  typedef struct packed {
    logic             first;
    logic             row0;
    logic [IDX_W-1:0] addr;
  } mac_tag_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    limb_t            data;
  } pwr_t;

endpackage

@@ src/mlhm_mac.sv @@
// ----------------------------------------------------------------------------
// mlhm_mac
// Three-stage limb multiply-accumulate: split multiply, partial product
// combine, then add of product limb and carry with write-back.
// ----------------------------------------------------------------------------
module mlhm_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  mlhm_pkg::mac_tag_t tag_i,
  input  mlhm_pkg::limb_t   a_i,
  input  mlhm_pkg::limb_t   b_i,
  input  mlhm_pkg::limb_t   p_i,
  output mlhm_pkg::pwr_t    wr_o
);

  localparam int HW  = mlhm_pkg::HALF_W;
  localparam int PW  = mlhm_pkg::PP_W;
  localparam int LB  = mlhm_pkg::LIMB_BITS;
  localparam int SW  = 2 * mlhm_pkg::LIMB_BITS;
  localparam int CW  = 4 * mlhm_pkg::HALF_W;

  logic [HW-1:0] a_lo, a_hi, b_lo, b_hi;

  logic               v2_q, v3_q;
  mlhm_pkg::mac_tag_t tag2_q, tag3_q;
  logic [PW-1:0]      ll_q, lh_q, hl_q, hh_q;
  mlhm_pkg::limb_t    p2_q, p3_q;
  logic [SW-1:0]      prod_q;
  mlhm_pkg::limb_t    carry_q;

  logic [CW-1:0]      comb_w;
  mlhm_pkg::limb_t    carry_in;
  logic [SW-1:0]      sum_w;

  assign a_lo = a_i[HW-1:0];
  assign b_lo = b_i[HW-1:0];
  assign a_hi = HW'(a_i >> HW);
  assign b_hi = HW'(b_i >> HW);

  assign comb_w = CW'(ll_q) + (CW'(lh_q) << HW) + (CW'(hl_q) << HW)
                + (CW'(hh_q) << (2 * HW));

  assign carry_in = tag3_q.first ? '0 : carry_q;
  assign sum_w    = prod_q + SW'(p3_q) + SW'(carry_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag_i;
    ll_q   <= PW'(a_lo) * PW'(b_lo);
    lh_q   <= PW'(a_lo) * PW'(b_hi);
    hl_q   <= PW'(a_hi) * PW'(b_lo);
    hh_q   <= PW'(a_hi) * PW'(b_hi);
    p2_q   <= tag_i.row0 ? '0 : p_i;
    tag3_q <= tag2_q;
    prod_q <= comb_w[SW-1:0];
    p3_q   <= p2_q;
    if (v3_q) begin
      carry_q <= sum_w[SW-1:LB];
    end
  end

  assign wr_o.we   = v3_q;
  assign wr_o.addr = tag3_q.addr;
  assign wr_o.data = sum_w[LB-1:0];

endmodule

@@ src/multiprecision_low_half_multiply.sv @@
// ----------------------------------------------------------------------------
// multiprecision_low_half_multiply
// Schoolbook short product of two multi-limb operands, low half only.
// ----------------------------------------------------------------------------
// Operand limb pairs are taken one per transaction, least significant first,
// at one per cycle; the transaction with last_limb set starts the product and
// the input stays closed until every result limb is taken. For n limbs the
// work is n(n+1)/2 issues to the single multiply-accumulate pipeline, with a
// drain after each of the n rows (a row reads product limbs the previous row
// writes), then each result limb is read from the product memory's read port
// in turn through the read, capture and send states. Row 0 overwrites the
// product memory, so no clearing pass runs after reset. Pairs beyond 32 are
// dropped and every result of that operand carries overflow.
module multiprecision_low_half_multiply (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] a_limb_i,
  input  logic [63:0] b_limb_i,
  input  logic        last_limb_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] product_limb_o,
  output logic [4:0]  limb_index_o,
  output logic        last_result_o,
  output logic        overflow_o
);

  localparam int IW = mlhm_pkg::IDX_W;
  localparam int NW = mlhm_pkg::CNT_W;
  localparam int LB = mlhm_pkg::LIMB_BITS;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_GAP,
    ST_TAIL,
    ST_ORD,
    ST_OCAP,
    ST_OSEND
  } state_e;

  state_e             state_q;
  logic [NW-1:0]      loaded_q, n_q;
  logic               ovf_q;
  logic [IW-1:0]      i_q, j_q, k_q;
  logic [mlhm_pkg::GAP_W-1:0] gap_q;
  logic               iss_valid_q;
  mlhm_pkg::mac_tag_t iss_tag_q;

  logic               out_valid_q, out_last_q, out_ovf_q;
  mlhm_pkg::limb_t    out_data_q;
  logic [IW-1:0]      out_idx_q;

  mlhm_pkg::limb_t    a_mem [mlhm_pkg::MAX_LIMBS];
  mlhm_pkg::limb_t    b_mem [mlhm_pkg::MAX_LIMBS];
  mlhm_pkg::limb_t    p_mem [mlhm_pkg::MAX_LIMBS];
  mlhm_pkg::limb_t    a_rd_q, b_rd_q, p_rd_q;

  logic               load_room, row_end, last_row, in_fire;
  logic [IW-1:0]      sum_idx, p_raddr;
  mlhm_pkg::pwr_t     pwr;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_room  = loaded_q < NW'(mlhm_pkg::MAX_LIMBS);
  assign sum_idx    = i_q + j_q;
  assign row_end    = (NW'(i_q) + NW'(j_q) + NW'(1)) == n_q;
  assign last_row   = (NW'(i_q) + NW'(1)) == n_q;
  assign p_raddr    = (state_q == ST_MAC) ? sum_idx : k_q;

  // operand and product memories
  always_ff @(posedge clk_i) begin
    if (in_fire && load_room) begin
      a_mem[loaded_q[IW-1:0]] <= a_limb_i[LB-1:0];
      b_mem[loaded_q[IW-1:0]] <= b_limb_i[LB-1:0];
    end
    a_rd_q <= a_mem[j_q];
    b_rd_q <= b_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (pwr.we) begin
      p_mem[pwr.addr] <= pwr.data;
    end
    p_rd_q <= p_mem[p_raddr];
  end

  mlhm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (iss_valid_q),
    .tag_i   (iss_tag_q),
    .a_i     (a_rd_q),
    .b_i     (b_rd_q),
    .p_i     (p_rd_q),
    .wr_o    (pwr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      gap_q       <= '0;
      iss_valid_q <= 1'b0;
      iss_tag_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      iss_valid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_room) begin
              loaded_q <= loaded_q + NW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_limb_i) begin
              n_q     <= load_room ? loaded_q + NW'(1) : loaded_q;
              i_q     <= '0;
              j_q     <= '0;
              state_q <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          iss_valid_q     <= 1'b1;
          iss_tag_q.first <= (j_q == '0);
          iss_tag_q.row0  <= (i_q == '0);
          iss_tag_q.addr  <= sum_idx;
          if (row_end) begin
            gap_q   <= mlhm_pkg::GAP_W'(mlhm_pkg::DRAIN_CYC - 1);
            state_q <= last_row ? ST_TAIL : ST_GAP;
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
        ST_GAP: begin
          if (gap_q == '0) begin
            i_q     <= i_q + IW'(1);
            j_q     <= '0;
            state_q <= ST_MAC;
          end else begin
            gap_q <= gap_q - mlhm_pkg::GAP_W'(1);
          end
        end
        ST_TAIL: begin
          if (gap_q == '0) begin
            k_q     <= '0;
            state_q <= ST_ORD;
          end else begin
            gap_q <= gap_q - mlhm_pkg::GAP_W'(1);
          end
        end
        ST_ORD: begin
          state_q <= ST_OCAP;
        end
        ST_OCAP: begin
          out_valid_q <= 1'b1;
          out_data_q  <= p_rd_q;
          out_idx_q   <= k_q;
          out_last_q  <= (NW'(k_q) + NW'(1)) == n_q;
          out_ovf_q   <= ovf_q;
          state_q     <= ST_OSEND;
        end
        ST_OSEND: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              loaded_q <= '0;
              ovf_q    <= 1'b0;
              state_q  <= ST_LOAD;
            end else begin
              k_q     <= k_q + IW'(1);
              state_q <= ST_ORD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign product_limb_o = mlhm_pkg::FIELD_W'(out_data_q);
  assign limb_index_o   = mlhm_pkg::OUT_IDX_W'(out_idx_q);
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

  // input and output sides never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result transaction is pending");

  // product writes happen only while the product is being built
  a_wr_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwr.we |-> (state_q == ST_MAC || state_q == ST_GAP || state_q == ST_TAIL))
    else $error("product memory write outside the multiply phase");

  // issued column stays inside the low half
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> ((NW'(i_q) + NW'(j_q)) < n_q))
    else $error("multiply issued beyond the operand length");

  // final result carries the top index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> ((NW'(out_idx_q) + NW'(1)) == n_q))
    else $error("last result flagged on the wrong limb");

  // a result is offered only after its read cycle
  a_out_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OCAP))
    else $error("result offered without a product read");

endmodule

@@ tb/multiprecision_low_half_multiply_tb.sv @@
// ----------------------------------------------------------------------------
// multiprecision_low_half_multiply_tb
// Self-checking testbench for the low-half multiprecision multiplier.
// ----------------------------------------------------------------------------
// Operand limb pairs go in least significant first. A local schoolbook
// short-product predictor keeps its own copy of the operand limbs and queues
// the low n product limbs whenever a closing pair with no typed answer is accepted. Every
// product limb that comes out is compared field by field with the oldest
// queued limb. A short table of directed pairs covers carries and limb
// extremes. Random operands of mostly small sizes follow, some of the full
// 32 limbs and some longer, so that the dropped-limb overflow path is taken.
// Both sides idle at random. The receiver holds off once for a long
// stretch, and the sender pauses once until all products have drained.
// ----------------------------------------------------------------------------
module multiprecision_low_half_multiply_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED   = 20;
  localparam int RANDOM_ITEMS = 250;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_AT      = 120;
  localparam int PAUSE_AT     = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_WAIT   = 60;
  localparam mlhm_pkg::limb_t ONES = '1;

  typedef struct packed {
    mlhm_pkg::limb_t                product;
    logic [mlhm_pkg::OUT_IDX_W-1:0] index;
    logic                           last;
    logic                           ovf;
  } product_limb_t;

  typedef struct {
    mlhm_pkg::limb_t a;
    mlhm_pkg::limb_t b;
    logic            last;
    logic            typed;
    mlhm_pkg::limb_t want;
  } pair_row_t;

  logic                           clk_i;
  logic                           rst_ni       = 1'b0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic [63:0]                    a_limb_i     = '0;
  logic [63:0]                    b_limb_i     = '0;
  logic                           last_limb_i  = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic [63:0]                    product_limb_o;
  logic [mlhm_pkg::OUT_IDX_W-1:0] limb_index_o;
  logic                           last_result_o;
  logic                           overflow_o;

  logic gaps_on = 1'b1;
  logic rx_hold = 1'b0;

  // predictor state
  mlhm_pkg::limb_t opa_limbs [mlhm_pkg::MAX_LIMBS];
  mlhm_pkg::limb_t opb_limbs [mlhm_pkg::MAX_LIMBS];
  int unsigned     limbs_held;
  logic            limbs_dropped;

  product_limb_t product_limbs_due [$];

  int errors         = 0;
  int items_sent     = 0;
  int products_begun = 0;
  int products_ovf   = 0;
  int limbs_checked  = 0;
  int idle_cycles    = 0;

  pair_row_t directed_rows [N_DIRECTED] = '{
    // single-limb products with the answer known up front
    '{64'h0, 64'h0, 1'b1, 1'b1, 64'h0},
    '{ONES, ONES, 1'b1, 1'b1, 64'h1},
    '{64'h1, ONES, 1'b1, 1'b1, ONES},
    '{ONES, 64'h1, 1'b1, 1'b1, ONES},
    '{64'h8000_0000_0000_0000, 64'h2, 1'b1, 1'b1, 64'h0},
    '{64'h1_0000_0000, 64'h1_0000_0000, 1'b1, 1'b1, 64'h0},
    '{64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFE_0000_0001},
    '{64'h5555_5555_5555_5555, 64'h3, 1'b1, 1'b1, ONES},
    // two limbs, all ones
    '{ONES, ONES, 1'b0, 1'b0, 64'h0},
    '{ONES, ONES, 1'b1, 1'b0, 64'h0},
    // three limbs, long carry chains
    '{ONES, 64'h1, 1'b0, 1'b0, 64'h0},
    '{ONES, ONES, 1'b0, 1'b0, 64'h0},
    '{64'h0, ONES, 1'b1, 1'b0, 64'h0},
    // four limbs, alternating bit patterns
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001, ONES, 1'b0, 1'b0, 64'h0},
    '{ONES, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
    // two limbs, top limb zero
    '{64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 64'h0},
    '{64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    // single limb through the predictor
    '{64'hDEAD_BEEF_0BAD_F00D, 64'hC0FF_EE00_1234_4321, 1'b1, 1'b0, 64'h0}
  };

  multiprecision_low_half_multiply DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .a_limb_i       (a_limb_i),
    .b_limb_i       (b_limb_i),
    .last_limb_i    (last_limb_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .product_limb_o (product_limb_o),
    .limb_index_o   (limb_index_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // low n limbs of a*b, row by row, carries past limb n-1 discarded
  task automatic mullo_take_pair(input mlhm_pkg::limb_t a, input mlhm_pkg::limb_t b,
                                 input logic last);
    mlhm_pkg::limb_t acc [mlhm_pkg::MAX_LIMBS];
    mlhm_pkg::limb_t carry;
    logic [127:0]    wide;
    product_limb_t   due;
    int unsigned     n;
    if (limbs_held < mlhm_pkg::MAX_LIMBS) begin
      opa_limbs[limbs_held] = a;
      opb_limbs[limbs_held] = b;
      limbs_held++;
    end else begin
      limbs_dropped = 1'b1;
    end
    if (last) begin
      n = limbs_held;
      for (int i = 0; i < n; i++) acc[i] = '0;
      for (int i = 0; i < n; i++) begin
        carry = '0;
        for (int j = 0; i + j < n; j++) begin
          wide = 128'(opa_limbs[j]) * 128'(opb_limbs[i]) + 128'(acc[i+j]) + 128'(carry);
          acc[i+j] = wide[63:0];
          carry    = wide[127:64];
        end
      end
      for (int k = 0; k < n; k++) begin
        due.product = acc[k];
        due.index   = k[mlhm_pkg::OUT_IDX_W-1:0];
        due.last    = (k + 1 == n);
        due.ovf     = limbs_dropped;
        product_limbs_due.push_back(due);
      end
      products_begun++;
      if (limbs_dropped) products_ovf++;
      limbs_held    = 0;
      limbs_dropped = 1'b0;
    end
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken, or later when a random gap follows
  task automatic send_pair(input mlhm_pkg::limb_t a, input mlhm_pkg::limb_t b,
                           input logic last, input logic typed,
                           input mlhm_pkg::limb_t want);
    product_limb_t due;
    in_valid_i  <= 1'b1;
    a_limb_i    <= a;
    b_limb_i    <= b;
    last_limb_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (typed) begin
      due.product = want;
      due.index   = '0;
      due.last    = 1'b1;
      due.ovf     = 1'b0;
      product_limbs_due.push_back(due);
      products_begun++;
    end else begin
      mullo_take_pair(a, b, last);
    end
    if (gaps_on && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic mlhm_pkg::limb_t rand_limb();
    mlhm_pkg::limb_t v;
    case ($urandom_range(9))
      6:       v = '0;
      7:       v = ONES;
      8:       v = mlhm_pkg::limb_t'(1) << $urandom_range(mlhm_pkg::LIMB_BITS - 1);
      9:       v = ONES >> $urandom_range(mlhm_pkg::LIMB_BITS - 1);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 93) return $urandom_range(mlhm_pkg::MAX_LIMBS - 2, mlhm_pkg::MAX_LIMBS);
    return $urandom_range(mlhm_pkg::MAX_LIMBS + 1, mlhm_pkg::MAX_LIMBS + 4);
  endfunction

  task automatic send_operand(input int len);
    for (int k = 0; k < len; k++) send_pair(rand_limb(), rand_limb(), k == len - 1, 1'b0, '0);
  endtask

  task automatic drain_products();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (product_limbs_due.size() != 0);
  endtask

  task automatic check_product_limb();
    product_limb_t due;
    if (product_limbs_due.size() == 0) begin
      $error("product limb %0d = %h with none expected", limb_index_o, product_limb_o);
      errors++;
    end else begin
      due = product_limbs_due.pop_front();
      limbs_checked++;
      if (product_limb_o !== due.product) begin
        $error("product_limb: expected %h, got %h", due.product, product_limb_o);
        errors++;
      end
      if (limb_index_o !== due.index) begin
        $error("limb_index: expected %0d, got %0d", due.index, limb_index_o);
        errors++;
      end
      if (last_result_o !== due.last) begin
        $error("last_result: expected %0b, got %0b", due.last, last_result_o);
        errors++;
      end
      if (overflow_o !== due.ovf) begin
        $error("overflow: expected %0b, got %0b", due.ovf, overflow_o);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_product_limb();
    out_ready_i <= rst_ni && !rx_hold && !(gaps_on && $urandom_range(99) < 16);
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (items_sent >= HOLD_AT);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bit paused;
    paused        = 1'b0;
    limbs_held    = 0;
    limbs_dropped = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    end
    drain_products();

    // stretch with no idling on either side
    gaps_on <= 1'b0;
    send_operand(mlhm_pkg::MAX_LIMBS);
    send_operand(mlhm_pkg::MAX_LIMBS + 1);
    while (items_sent < N_DIRECTED + QUIET_ITEMS) send_operand(pick_len());
    gaps_on <= 1'b1;

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      send_operand(pick_len());
      if (!paused && items_sent >= PAUSE_AT) begin
        drain_products();
        paused = 1'b1;
      end
    end
    in_valid_i <= 1'b0;

    while (product_limbs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d limb pairs forming %0d products, %0d of them with dropped limbs",
             items_sent, products_begun, products_ovf);
    $display("checked %0d product limbs, %0d mismatches", limbs_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
